[hdl/unv_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 name validator package
// Widths, register indexes, reset values and character set helpers.
// ----------------------------------------------------------------------------
package unv_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned CP_W        = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_NAME_BYTES = 2'd0,
    REG_MIN_NAME_CHARS = 2'd1,
    REG_MAX_NAME_CHARS = 2'd2
  } cfg_reg_t;

  localparam logic [COUNT_W-1:0] MAX_NAME_BYTES_RST = 8'd32;
  localparam logic [COUNT_W-1:0] MIN_NAME_CHARS_RST = 8'd2;
  localparam logic [COUNT_W-1:0] MAX_NAME_CHARS_RST = 8'd12;
  localparam logic [COUNT_W-1:0] COUNT_SAT          = 8'd255;

  localparam logic [CP_W-1:0] CJK_FIRST      = 16'h4E00;
  localparam logic [CP_W-1:0] CJK_LAST       = 16'h9FFF;
  localparam logic [CP_W-1:0] TWO_BYTE_FLOOR = 16'h0080;
  localparam logic [CP_W-1:0] THR_BYTE_FLOOR = 16'h0800;

  // ASCII letter, digit, underscore, or CJK unified ideograph
  function automatic logic char_allowed(input logic [CP_W-1:0] cp);
    logic ascii_ok;
    ascii_ok = ((cp >= 16'h0061) && (cp <= 16'h007A)) ||
               ((cp >= 16'h0041) && (cp <= 16'h005A)) ||
               ((cp >= 16'h0030) && (cp <= 16'h0039)) ||
               (cp == 16'h005F);
    if (cp <= 16'h007F) return ascii_ok;
    return (cp >= CJK_FIRST) && (cp <= CJK_LAST);
  endfunction

endpackage

[hdl/unv_if.sv]
// ----------------------------------------------------------------------------
// UTF-8 name validator channels
// Name byte stream, result stream and register write channel.
// ----------------------------------------------------------------------------
interface unv_byte_if import unv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] name_byte;
  logic              last_byte;

  modport source (output valid, output name_byte, output last_byte, input ready);
  modport sink   (input valid, input name_byte, input last_byte, output ready);
endinterface

interface unv_result_if import unv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               name_valid;
  logic [COUNT_W-1:0] char_total;

  modport source (output valid, output name_valid, output char_total, input ready);
  modport sink   (input valid, input name_valid, input char_total, output ready);
endinterface

interface unv_cfg_if import unv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [COUNT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/utf8_name_charset_validator.sv]
// ----------------------------------------------------------------------------
// UTF-8 name charset validator
// Decodes a name one byte per request and checks charset, lengths and form.
// ----------------------------------------------------------------------------
// Path: an accepted last byte is held in the input register, then decoded
//   into the result register.
// Throughput: one byte per cycle while results are taken; a waiting result
//   holds the decode stage, and input stops once the input register is full.
// Reset: rst (synchronous) clears decode state and the pipeline valids and
//   loads the limit registers with 32 bytes, 2 and 12 characters.
module utf8_name_charset_validator import unv_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  unv_byte_if.sink   name_in,
  unv_cfg_if.sink    cfg,
  unv_result_if.source result
);

  logic [COUNT_W-1:0] max_name_bytes;
  logic [COUNT_W-1:0] min_name_chars;
  logic [COUNT_W-1:0] max_name_chars;

  // input register
  logic              stage_valid;
  logic [BYTE_W-1:0] stage_byte;
  logic              stage_last;

  // decode state
  logic [1:0]         bytes_pending, bytes_pending_next;
  logic [1:0]         sequence_length, sequence_length_next;
  logic [CP_W-1:0]    partial_code_point, partial_code_point_next;
  logic [COUNT_W-1:0] char_counter, char_counter_next;
  logic [COUNT_W-1:0] byte_counter, byte_counter_next;
  logic               error_seen, error_seen_next;
  logic               name_ok;

  logic advance;

  assign advance       = !result.valid || result.ready;
  assign name_in.ready = !stage_valid || advance;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_bytes <= MAX_NAME_BYTES_RST;
      min_name_chars <= MIN_NAME_CHARS_RST;
      max_name_chars <= MAX_NAME_CHARS_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_MAX_NAME_BYTES: max_name_bytes <= cfg.data;
        REG_MIN_NAME_CHARS: min_name_chars <= cfg.data;
        REG_MAX_NAME_CHARS: max_name_chars <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [CP_W-1:0] cp;
    logic            accept_cp;
    bytes_pending_next      = bytes_pending;
    sequence_length_next    = sequence_length;
    partial_code_point_next = partial_code_point;
    char_counter_next       = char_counter;
    byte_counter_next       = byte_counter;
    error_seen_next         = error_seen;
    cp                      = {{(CP_W-BYTE_W){1'b0}}, stage_byte};
    accept_cp               = 1'b0;

    if (byte_counter == COUNT_SAT) error_seen_next = 1'b1;
    else byte_counter_next = byte_counter + 1'b1;
    if (byte_counter_next > max_name_bytes) error_seen_next = 1'b1;

    if (!error_seen_next) begin
      if (bytes_pending == 2'd0) begin
        priority if (!stage_byte[7]) begin
          accept_cp = 1'b1;
        end else if (stage_byte[7:5] == 3'b110) begin
          bytes_pending_next      = 2'd1;
          sequence_length_next    = 2'd2;
          partial_code_point_next = {11'd0, stage_byte[4:0]};
        end else if (stage_byte[7:4] == 4'b1110) begin
          bytes_pending_next      = 2'd2;
          sequence_length_next    = 2'd3;
          partial_code_point_next = {12'd0, stage_byte[3:0]};
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (stage_byte[7:6] != 2'b10) begin
        error_seen_next = 1'b1;
      end else begin
        cp                      = {partial_code_point[CP_W-7:0], stage_byte[5:0]};
        partial_code_point_next = cp;
        bytes_pending_next      = bytes_pending - 2'd1;
        if (bytes_pending_next == 2'd0) begin
          sequence_length_next    = 2'd0;
          partial_code_point_next = '0;
          if (cp < ((sequence_length == 2'd2) ? TWO_BYTE_FLOOR : THR_BYTE_FLOOR))
            error_seen_next = 1'b1;
          else
            accept_cp = 1'b1;
        end
      end
    end

    if (accept_cp) begin
      if (!char_allowed(cp)) error_seen_next = 1'b1;
      else if (char_counter != COUNT_SAT) char_counter_next = char_counter + 1'b1;
    end

    name_ok = !error_seen_next && (bytes_pending_next == 2'd0) &&
              (char_counter_next >= min_name_chars) &&
              (char_counter_next <= max_name_chars);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid        <= 1'b0;
      result.valid       <= 1'b0;
      bytes_pending      <= 2'd0;
      sequence_length    <= 2'd0;
      partial_code_point <= '0;
      char_counter       <= '0;
      byte_counter       <= '0;
      error_seen         <= 1'b0;
    end else begin
      if (name_in.ready) begin
        stage_valid <= name_in.valid;
        stage_byte  <= name_in.name_byte;
        stage_last  <= name_in.last_byte;
      end
      if (advance) begin
        result.valid      <= stage_valid && stage_last;
        result.name_valid <= name_ok;
        result.char_total <= char_counter_next;
      end
      if (stage_valid && advance) begin
        if (stage_last) begin
          // drop name state once its result is loaded
          bytes_pending      <= 2'd0;
          sequence_length    <= 2'd0;
          partial_code_point <= '0;
          char_counter       <= '0;
          byte_counter       <= '0;
          error_seen         <= 1'b0;
        end else begin
          bytes_pending      <= bytes_pending_next;
          sequence_length    <= sequence_length_next;
          partial_code_point <= partial_code_point_next;
          char_counter       <= char_counter_next;
          byte_counter       <= byte_counter_next;
          error_seen         <= error_seen_next;
        end
      end
    end
  end

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(stage_valid && stage_last))
    else $error("result without a last byte in the input register");

  a_seq_open_match: assert property (@(posedge clk) disable iff (rst)
    (bytes_pending == 2'd0) == (sequence_length == 2'd0))
    else $error("pending count and sequence length disagree");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_seen && !(stage_valid && advance && stage_last) |=> error_seen)
    else $error("error flag cleared inside a name");

  a_chars_frozen: assert property (@(posedge clk) disable iff (rst)
    error_seen && !(stage_valid && advance && stage_last) |=> $stable(char_counter))
    else $error("character count moved after an error");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid && $stable(stage_byte))
    else $error("input register lost a byte while stalled");

endmodule

[tb/tb_utf8_name_charset_validator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF-8 name charset validator testbench
// Streams names one byte per request through the validator, predicts each
// verdict with a behavioral decoder, or from a typed row, and compares it with
// every result. A short directed table comes first, then random names under
// several limit settings, with random gaps on the byte side and result stalls.
// ----------------------------------------------------------------------------
module tb_utf8_name_charset_validator;
  import unv_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [BYTE_W-1:0]  b;
    logic               last;
    logic               typed;
    logic               exp_ok;
    logic [COUNT_W-1:0] exp_chars;
  } name_req_t;

  typedef struct packed {
    logic               ok;
    logic [COUNT_W-1:0] chars;
  } verdict_t;

  localparam logic [9:0] NO_CHECK = '0;

  // bytes, last flag, then either no typed verdict or {1, valid, chars}
  name_req_t dir_rows [0:24] = '{
    // shortest name inside the reset bounds
    {8'h61, 1'b0, NO_CHECK},
    {8'h42, 1'b1, 1'b1, 1'b1, 8'd2},
    // one character, below the minimum
    {8'h5F, 1'b1, 1'b1, 1'b0, 8'd1},
    // first and last CJK ideograph
    {8'hE4, 1'b0, NO_CHECK},
    {8'hB8, 1'b0, NO_CHECK},
    {8'h80, 1'b0, NO_CHECK},
    {8'hE9, 1'b0, NO_CHECK},
    {8'hBF, 1'b0, NO_CHECK},
    {8'hBF, 1'b1, NO_CHECK},
    // zero byte
    {8'h00, 1'b1, 1'b1, 1'b0, 8'd0},
    // stray continuation as lead
    {8'h80, 1'b0, NO_CHECK},
    {8'h61, 1'b1, 1'b1, 1'b0, 8'd0},
    // lead bytes from F0 up to FF, both ends
    {8'hFF, 1'b1, 1'b1, 1'b0, 8'd0},
    {8'h61, 1'b0, NO_CHECK},
    {8'hF0, 1'b1, 1'b1, 1'b0, 8'd1},
    // lead followed by a non-continuation
    {8'hC3, 1'b0, NO_CHECK},
    {8'h61, 1'b1, 1'b1, 1'b0, 8'd0},
    // overlong two-byte and three-byte forms
    {8'hC1, 1'b0, NO_CHECK},
    {8'hBF, 1'b1, 1'b1, 1'b0, 8'd0},
    {8'hE0, 1'b0, NO_CHECK},
    {8'h9F, 1'b0, NO_CHECK},
    {8'hBF, 1'b1, 1'b1, 1'b0, 8'd0},
    // sequence cut off by the end of the name
    {8'h61, 1'b0, NO_CHECK},
    {8'h62, 1'b0, NO_CHECK},
    {8'hE4, 1'b1, 1'b1, 1'b0, 8'd2}
  };

  logic clk;
  logic rst;

  unv_byte_if   name_ch ();
  unv_cfg_if    cfg_ch ();
  unv_result_if res_ch ();

  utf8_name_charset_validator dut (
    .clk     (clk),
    .rst     (rst),
    .name_in (name_ch),
    .cfg     (cfg_ch),
    .result  (res_ch)
  );

  // limit registers as last written
  logic [COUNT_W-1:0] lim_bytes = MAX_NAME_BYTES_RST;
  logic [COUNT_W-1:0] lim_min   = MIN_NAME_CHARS_RST;
  logic [COUNT_W-1:0] lim_max   = MAX_NAME_CHARS_RST;

  // decoder state of the name in progress
  logic [1:0]         dec_pending = '0;
  logic [1:0]         dec_seq_len = '0;
  logic [CP_W-1:0]    dec_cp      = '0;
  logic [COUNT_W-1:0] dec_chars   = '0;
  logic [COUNT_W-1:0] dec_bytes   = '0;
  logic               dec_err     = 1'b0;

  name_req_t   req_q [$];
  verdict_t    verdict_q [$];
  name_req_t   cur_req = '0;
  logic        byte_taken = 1'b0;
  logic        calm = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic in_charset(input logic [CP_W-1:0] cp);
    if (cp < 16'h0080) begin
      return (cp >= "a" && cp <= "z") || (cp >= "A" && cp <= "Z") ||
             (cp >= "0" && cp <= "9") || cp == "_";
    end
    return cp >= CJK_FIRST && cp <= CJK_LAST;
  endfunction

  task automatic scan_name_byte(input logic [BYTE_W-1:0] b, input logic last,
                                output logic done, output verdict_t v);
    logic            have_cp;
    logic [CP_W-1:0] cp;
    have_cp = 1'b0;
    cp = '0;
    done = 1'b0;
    v = '0;
    if (dec_bytes == COUNT_SAT) dec_err = 1'b1;
    else dec_bytes++;
    if (dec_bytes > lim_bytes) dec_err = 1'b1;
    if (!dec_err) begin
      if (dec_pending == 2'd0) begin
        if (!b[7]) begin
          have_cp = 1'b1;
          cp = {8'h00, b};
        end else if (b[7:5] == 3'b110) begin
          dec_pending = 2'd1;
          dec_seq_len = 2'd2;
          dec_cp = {11'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
          dec_pending = 2'd2;
          dec_seq_len = 2'd3;
          dec_cp = {12'd0, b[3:0]};
        end else begin
          dec_err = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        dec_err = 1'b1;
      end else begin
        dec_cp = {dec_cp[CP_W-7:0], b[5:0]};
        dec_pending--;
        if (dec_pending == 2'd0) begin
          if (dec_cp < ((dec_seq_len == 2'd2) ? TWO_BYTE_FLOOR : THR_BYTE_FLOOR)) begin
            dec_err = 1'b1;
          end else begin
            have_cp = 1'b1;
            cp = dec_cp;
          end
          dec_seq_len = '0;
          dec_cp = '0;
        end
      end
      if (have_cp) begin
        if (!in_charset(cp)) dec_err = 1'b1;
        else if (dec_chars != COUNT_SAT) dec_chars++;
      end
    end
    if (last) begin
      done = 1'b1;
      v.ok = !dec_err && dec_pending == 2'd0 && dec_chars >= lim_min &&
             dec_chars <= lim_max;
      v.chars = dec_chars;
      dec_pending = '0;
      dec_seq_len = '0;
      dec_cp = '0;
      dec_chars = '0;
      dec_bytes = '0;
      dec_err = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // byte side: hold a request until taken, gaps come in bursts
  always @(negedge clk) begin
    if (rst) begin
      name_ch.valid = 1'b0;
    end else if (!name_ch.valid || byte_taken) begin
      byte_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        name_ch.valid = 1'b0;
      end else if (!calm && req_q.size() > 0 && $urandom_range(0, 15) == 0) begin
        gap_left = $urandom_range(1, 12) - 1;
        name_ch.valid = 1'b0;
      end else if (req_q.size() > 0) begin
        cur_req = req_q.pop_front();
        name_ch.name_byte = cur_req.b;
        name_ch.last_byte = cur_req.last;
        name_ch.valid = 1'b1;
      end else begin
        name_ch.valid = 1'b0;
      end
    end
  end

  // result side: stall in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      res_ch.ready = 1'b0;
    end else if (!calm && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      res_ch.ready = 1'b0;
    end else begin
      res_ch.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    logic     done;
    verdict_t v;
    verdict_t want;
    if (!rst) begin
      if (name_ch.valid && name_ch.ready) begin
        byte_taken = 1'b1;
        scan_name_byte(name_ch.name_byte, name_ch.last_byte, done, v);
        if (done) begin
          if (cur_req.typed) v = {cur_req.exp_ok, cur_req.exp_chars};
          verdict_q.push_back(v);
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result valid=%0d chars=%0d with none pending",
                                    res_ch.name_valid, res_ch.char_total));
        end else begin
          want = verdict_q.pop_front();
          if (res_ch.name_valid !== want.ok)
            report_mismatch($sformatf("name_valid %0d, want %0d",
                                      res_ch.name_valid, want.ok));
          if (res_ch.char_total !== want.chars)
            report_mismatch($sformatf("char_total %0d, want %0d",
                                      res_ch.char_total, want.chars));
        end
      end
    end
  end

  // watchdog on cycles with no request moving on any channel
  always @(posedge clk) begin
    if ((name_ch.valid && name_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic write_limit(input cfg_reg_t idx, input logic [COUNT_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_MAX_NAME_BYTES: lim_bytes = val;
      REG_MIN_NAME_CHARS: lim_min = val;
      REG_MAX_NAME_CHARS: lim_max = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_limits(input logic [COUNT_W-1:0] max_bytes,
                            input logic [COUNT_W-1:0] min_chars,
                            input logic [COUNT_W-1:0] max_chars);
    write_limit(REG_MAX_NAME_BYTES, max_bytes);
    write_limit(REG_MIN_NAME_CHARS, min_chars);
    write_limit(REG_MAX_NAME_CHARS, max_chars);
  endtask

  // wait for every byte and verdict, then let the pipeline drain
  task automatic settle();
    while (req_q.size() != 0 || name_ch.valid || verdict_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_name_char();
    int unsigned v;
    v = $urandom_range(0, 62);
    if (v < 26) return BYTE_W'(8'h61 + v);
    if (v < 52) return BYTE_W'(8'h41 + (v - 26));
    if (v < 62) return BYTE_W'(8'h30 + (v - 52));
    return 8'h5F;
  endfunction

  task automatic push_name(input logic [BYTE_W-1:0] bq [$]);
    name_req_t r;
    for (int i = 0; i < bq.size(); i++) begin
      r = '0;
      r.b = bq[i];
      r.last = (i == bq.size() - 1);
      req_q.push_back(r);
    end
  endtask

  task automatic queue_ascii_name(input int len);
    logic [BYTE_W-1:0] bq [$];
    repeat (len) bq.push_back(pick_name_char());
    push_name(bq);
  endtask

  // mostly well-formed names, with bad bytes, odd code points and cut-offs mixed in
  task automatic queue_names(input int count, input int max_chars);
    logic [BYTE_W-1:0] bq [$];
    logic [BYTE_W-1:0] b8;
    logic [CP_W-1:0]   cp;
    int unsigned       kind;
    repeat (count) begin
      bq.delete();
      repeat ($urandom_range(0, max_chars)) begin
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
          bq.push_back(pick_name_char());
        end else if (kind < 83) begin
          if (kind < 78) cp = CP_W'($urandom_range(CJK_FIRST, CJK_LAST));
          else cp = CP_W'($urandom());
          bq.push_back({4'hE, cp[15:12]});
          bq.push_back({2'b10, cp[11:6]});
          bq.push_back({2'b10, cp[5:0]});
        end else if (kind < 87) begin
          cp = CP_W'($urandom_range(0, 16'h07FF));
          bq.push_back({3'b110, cp[10:6]});
          bq.push_back({2'b10, cp[5:0]});
        end else if (kind < 90) begin
          bq.push_back(8'h00);
        end else if (kind < 94) begin
          b8 = BYTE_W'($urandom_range(0, 8'h7F));
          bq.push_back(b8);
        end else if (kind < 97) begin
          b8 = BYTE_W'($urandom_range(8'hC2, 8'hEF));
          bq.push_back(b8);
          b8 = BYTE_W'($urandom());
          bq.push_back(b8);
        end else begin
          b8 = BYTE_W'($urandom());
          bq.push_back(b8);
        end
      end
      if ($urandom_range(0, 9) == 0 || bq.size() == 0) begin
        b8 = BYTE_W'($urandom());
        bq.push_back(b8);
      end
      push_name(bq);
    end
  endtask

  initial begin
    rst = 1'b1;
    name_ch.valid = 1'b0;
    name_ch.name_byte = '0;
    name_ch.last_byte = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MAX_NAME_BYTES;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) req_q.push_back(dir_rows[i]);
    settle();

    set_limits(8'd255, 8'd0, 8'd255);
    queue_names(8, 10);
    queue_ascii_name(258);
    settle();

    set_limits(8'd1, 8'd0, 8'd1);
    queue_names(12, 3);
    settle();

    set_limits(8'd8, 8'd3, 8'd6);
    queue_names(15, 9);
    settle();

    set_limits(8'd255, 8'd255, 8'd255);
    queue_ascii_name(255);
    queue_names(4, 12);
    settle();

    // min above max: nothing can pass
    set_limits(8'd5, 8'd10, 8'd2);
    queue_names(8, 12);
    settle();

    repeat (3) begin
      set_limits(COUNT_W'($urandom_range(1, 40)), COUNT_W'($urandom_range(0, 10)),
                 COUNT_W'($urandom_range(0, 16)));
      queue_names(8, 14);
      settle();
    end

    calm = 1'b1;
    set_limits(MAX_NAME_BYTES_RST, MIN_NAME_CHARS_RST, MAX_NAME_CHARS_RST);
    queue_names(12, 14);
    settle();

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
